>>> sv/ssp_pkg.sv
// Shared types and status codes for the sparse-set component pool bank.
`timescale 1ns / 1ps
package ssp_pkg;

  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 10;
  localparam int COUNT_W  = 11;

  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [COUNT_W-1:0]  count_t;

  localparam status_t ST_ADDED   = 3'd0;
  localparam status_t ST_PRESENT = 3'd1;
  localparam status_t ST_REMOVED = 3'd2;
  localparam status_t ST_ABSENT  = 3'd3;
  localparam status_t ST_FULL    = 3'd4;

  typedef struct packed {
    status_t status;
    slot_t   slot;
    logic    moved;
    slot_t   moved_from;
    count_t  pool_count;
  } res_t;

endpackage

>>> sv/ssp_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module ssp_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/ssp_engine.sv
// Request sequencer: clear pass, sparse/dense lookup, add and swap-remove write-back.
`timescale 1ns / 1ps
module ssp_engine #(
  parameter int NUM_POOLS  = 8,
  parameter int POOL_DEPTH = 1024,
  parameter int INDEX_BITS = 10,
  parameter int GEN_BITS   = 6
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic in_mode,
  input  logic [2:0] in_pool,
  input  logic [15:0] in_handle,
  output logic res_valid,
  input  logic res_ready,
  output ssp_pkg::res_t res,
  output logic sp_we,
  output logic [((NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1) + INDEX_BITS - 1:0] sp_waddr,
  output logic [$clog2(POOL_DEPTH + 1)-1:0] sp_wdata,
  output logic [((NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1) + INDEX_BITS - 1:0] sp_raddr,
  input  logic [$clog2(POOL_DEPTH + 1)-1:0] sp_rdata,
  output logic dn_we,
  output logic [((NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1) + $clog2(POOL_DEPTH) - 1:0] dn_waddr,
  output logic [((INDEX_BITS + GEN_BITS < 16) ? INDEX_BITS + GEN_BITS : 16)-1:0] dn_wdata,
  output logic [((NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1) + $clog2(POOL_DEPTH) - 1:0] dn_raddr,
  input  logic [((INDEX_BITS + GEN_BITS < 16) ? INDEX_BITS + GEN_BITS : 16)-1:0] dn_rdata
);

  localparam int POOL_BITS = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
  localparam int CNT_BITS  = $clog2(POOL_DEPTH + 1);
  localparam int SLOT_BITS = $clog2(POOL_DEPTH);
  localparam int H_BITS    = (INDEX_BITS + GEN_BITS < 16) ? INDEX_BITS + GEN_BITS : 16;
  localparam int IDX_TAKE  = (INDEX_BITS < H_BITS) ? INDEX_BITS : H_BITS;
  localparam int SP_AW     = POOL_BITS + INDEX_BITS;
  localparam logic [SP_AW-1:0] CLR_LAST = SP_AW'(NUM_POOLS * (2 ** INDEX_BITS) - 1);
  localparam logic [CNT_BITS-1:0] DEPTH_C = CNT_BITS'(POOL_DEPTH);
  localparam logic [CNT_BITS-1:0] INVALID = '1;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_SPARSE, S_DENSE, S_MOVE, S_CLR, S_EMIT
  } state_t;

  state_t st;
  logic [SP_AW-1:0] clr;
  logic [CNT_BITS-1:0] fill [NUM_POOLS];
  logic mode_r;
  logic [POOL_BITS-1:0] pool_r;
  logic [H_BITS-1:0] hnd_r;
  logic [INDEX_BITS-1:0] idx_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic [CNT_BITS-1:0] ind_r;

  logic accept;
  logic in_ok;
  logic [POOL_BITS-1:0] in_pool_p;
  logic [H_BITS-1:0] in_hnd;
  logic [INDEX_BITS-1:0] in_idx;
  logic [INDEX_BITS-1:0] mv_idx;
  logic [CNT_BITS-1:0] last;
  logic member;
  logic full;
  logic do_move;

  assign in_hnd    = in_handle[H_BITS-1:0];
  assign in_idx    = INDEX_BITS'(in_hnd[IDX_TAKE-1:0]);
  assign mv_idx    = INDEX_BITS'(dn_rdata[IDX_TAKE-1:0]);
  assign in_pool_p = POOL_BITS'(in_pool);
  assign in_ok     = 32'(in_pool) < 32'(NUM_POOLS);
  assign in_ready  = (st == S_IDLE) || ((st == S_EMIT) && res_ready);
  assign accept    = in_valid && in_ready;
  assign res_valid = (st == S_EMIT);
  assign last      = cnt_r - CNT_BITS'(1);
  assign member    = (ind_r < cnt_r) && (dn_rdata == hnd_r);
  assign full      = (cnt_r >= DEPTH_C);
  assign do_move   = (last > ind_r);

  always_comb begin
    sp_raddr = {in_pool_p, in_idx};
    dn_raddr = (st == S_DENSE) ? {pool_r, last[SLOT_BITS-1:0]}
                               : {pool_r, sp_rdata[SLOT_BITS-1:0]};
    sp_we    = 1'b0;
    sp_waddr = {pool_r, idx_r};
    sp_wdata = INVALID;
    dn_we    = 1'b0;
    dn_waddr = {pool_r, cnt_r[SLOT_BITS-1:0]};
    dn_wdata = hnd_r;
    case (st)
      S_INIT: begin
        sp_we    = 1'b1;
        sp_waddr = clr;
      end
      S_DENSE: begin
        if (!mode_r) begin
          if (!member && !full) begin
            sp_we    = 1'b1;
            sp_wdata = cnt_r;
            dn_we    = 1'b1;
          end
        end else if (member && !do_move) begin
          sp_we = 1'b1;
        end
      end
      S_MOVE: begin
        sp_we    = 1'b1;
        sp_waddr = {pool_r, mv_idx};
        sp_wdata = ind_r;
        dn_we    = 1'b1;
        dn_waddr = {pool_r, ind_r[SLOT_BITS-1:0]};
        dn_wdata = dn_rdata;
      end
      S_CLR: begin
        sp_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= S_INIT;
      clr <= '0;
      for (int i = 0; i < NUM_POOLS; i++) begin
        fill[i] <= '0;
      end
    end else begin
      case (st)
        S_INIT: begin
          clr <= clr + SP_AW'(1);
          if (clr == CLR_LAST) begin
            st <= S_IDLE;
          end
        end
        S_IDLE, S_EMIT: begin
          if (accept) begin
            mode_r <= in_mode;
            pool_r <= in_pool_p;
            hnd_r  <= in_hnd;
            idx_r  <= in_idx;
            if (!in_ok) begin
              res.status     <= in_mode ? ssp_pkg::ST_ABSENT : ssp_pkg::ST_FULL;
              res.slot       <= '0;
              res.moved      <= 1'b0;
              res.moved_from <= '0;
              res.pool_count <= '0;
              st             <= S_EMIT;
            end else begin
              cnt_r <= fill[in_pool_p];
              st    <= S_SPARSE;
            end
          end else if (st == S_EMIT && res_ready) begin
            st <= S_IDLE;
          end
        end
        S_SPARSE: begin
          ind_r <= sp_rdata;
          st    <= S_DENSE;
        end
        S_DENSE: begin
          res.moved      <= 1'b0;
          res.moved_from <= '0;
          st             <= S_EMIT;
          if (!mode_r) begin
            if (member) begin
              res.status     <= ssp_pkg::ST_PRESENT;
              res.slot       <= ssp_pkg::slot_t'(ind_r);
              res.pool_count <= ssp_pkg::count_t'(cnt_r);
            end else if (full) begin
              res.status     <= ssp_pkg::ST_FULL;
              res.slot       <= '0;
              res.pool_count <= ssp_pkg::count_t'(cnt_r);
            end else begin
              fill[pool_r]   <= cnt_r + CNT_BITS'(1);
              res.status     <= ssp_pkg::ST_ADDED;
              res.slot       <= ssp_pkg::slot_t'(cnt_r);
              res.pool_count <= ssp_pkg::count_t'(cnt_r + CNT_BITS'(1));
            end
          end else if (!member) begin
            res.status     <= ssp_pkg::ST_ABSENT;
            res.slot       <= '0;
            res.pool_count <= ssp_pkg::count_t'(cnt_r);
          end else if (do_move) begin
            st <= S_MOVE;
          end else begin
            fill[pool_r]   <= last;
            res.status     <= ssp_pkg::ST_REMOVED;
            res.slot       <= ssp_pkg::slot_t'(ind_r);
            res.pool_count <= ssp_pkg::count_t'(last);
          end
        end
        S_MOVE: begin
          st <= S_CLR;
        end
        S_CLR: begin
          fill[pool_r]   <= last;
          res.status     <= ssp_pkg::ST_REMOVED;
          res.slot       <= ssp_pkg::slot_t'(ind_r);
          res.moved      <= 1'b1;
          res.moved_from <= ssp_pkg::slot_t'(last);
          res.pool_count <= ssp_pkg::count_t'(last);
          st             <= S_EMIT;
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    st == S_DENSE |-> cnt_r <= DEPTH_C)
    else $error("pool count above depth");

  a_move_seq: assert property (@(posedge clk) disable iff (rst)
    st == S_MOVE |=> st == S_CLR && sp_we && sp_wdata == INVALID)
    else $error("swap-remove did not invalidate the removed index");

  a_add_emit: assert property (@(posedge clk) disable iff (rst)
    st == S_DENSE && dn_we |=> st == S_EMIT && res.status == ssp_pkg::ST_ADDED)
    else $error("dense write without an add result");

  a_moved_kind: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.moved |-> res.status == ssp_pkg::ST_REMOVED)
    else $error("move reported outside a remove");

endmodule

>>> sv/sparse_set_component_pool.sv
// Top level: sparse and dense memories, request sequencer and output register.
// Sequence: SPARSE reads the sparse memory, DENSE the dependent dense memory, EMIT passes the
// result to the output register; a moving remove adds MOVE and CLR, an out-of-range pool goes
// straight to EMIT. A new request is taken only as the previous result leaves the sequencer.
// Reset: pool counts clear in reset; the sparse memory is then swept to the invalid mark, all
// NUM_POOLS * 2**INDEX_BITS entries (8192 by default), with s_tready low.
`timescale 1ns / 1ps
module sparse_set_component_pool #(
  parameter int NUM_POOLS  = 8,
  parameter int POOL_DEPTH = 1024,
  parameter int INDEX_BITS = 10,
  parameter int GEN_BITS   = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // entity_handle
  input  logic [3:0]  s_tuser,  // mode, pool_select
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // slot, moved, moved_from, pool_count
  output logic [2:0]  m_tuser   // status
);

  localparam int POOL_BITS = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
  localparam int CNT_BITS  = $clog2(POOL_DEPTH + 1);
  localparam int SLOT_BITS = $clog2(POOL_DEPTH);
  localparam int H_BITS    = (INDEX_BITS + GEN_BITS < 16) ? INDEX_BITS + GEN_BITS : 16;
  localparam int SP_AW     = POOL_BITS + INDEX_BITS;
  localparam int DN_AW     = POOL_BITS + SLOT_BITS;

  logic res_valid;
  logic res_ready;
  ssp_pkg::res_t res;

  logic sp_we;
  logic [SP_AW-1:0] sp_waddr;
  logic [SP_AW-1:0] sp_raddr;
  logic [CNT_BITS-1:0] sp_wdata;
  logic [CNT_BITS-1:0] sp_rdata;
  logic dn_we;
  logic [DN_AW-1:0] dn_waddr;
  logic [DN_AW-1:0] dn_raddr;
  logic [H_BITS-1:0] dn_wdata;
  logic [H_BITS-1:0] dn_rdata;

  ssp_ram #(.DATA_W(CNT_BITS), .ADDR_W(SP_AW)) u_sparse (
    .clk(clk), .we(sp_we), .waddr(sp_waddr), .wdata(sp_wdata),
    .raddr(sp_raddr), .rdata(sp_rdata)
  );

  ssp_ram #(.DATA_W(H_BITS), .ADDR_W(DN_AW)) u_dense (
    .clk(clk), .we(dn_we), .waddr(dn_waddr), .wdata(dn_wdata),
    .raddr(dn_raddr), .rdata(dn_rdata)
  );

  ssp_engine #(
    .NUM_POOLS(NUM_POOLS), .POOL_DEPTH(POOL_DEPTH),
    .INDEX_BITS(INDEX_BITS), .GEN_BITS(GEN_BITS)
  ) u_engine (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .in_mode(s_tuser[0]), .in_pool(s_tuser[3:1]), .in_handle(s_tdata),
    .res_valid(res_valid), .res_ready(res_ready), .res(res),
    .sp_we(sp_we), .sp_waddr(sp_waddr), .sp_wdata(sp_wdata),
    .sp_raddr(sp_raddr), .sp_rdata(sp_rdata),
    .dn_we(dn_we), .dn_waddr(dn_waddr), .dn_wdata(dn_wdata),
    .dn_raddr(dn_raddr), .dn_rdata(dn_rdata)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
    if (res_valid && res_ready) begin
      m_tuser <= res.status;
      m_tdata <= {res.pool_count, res.moved_from, res.moved, res.slot};
    end
  end

endmodule
